[hdl/gat_pkg.sv]
// Package with the sequencer states, operation codes and status codes of the graph table.
package gat_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_LEN_U,
    S_LEN_V,
    S_CHECK,
    S_WR_U,
    S_WR_V,
    S_REG,
    S_NB,
    S_Q,
    S_QD,
    S_RESP
  } gat_state_t;

  typedef logic [1:0] gat_op_t;
  typedef logic [1:0] gat_status_t;

  localparam gat_op_t OP_ADD    = 2'd0;
  localparam gat_op_t OP_HAS    = 2'd1;
  localparam gat_op_t OP_COUNT  = 2'd2;
  localparam gat_op_t OP_DEGREE = 2'd3;

  localparam gat_status_t ST_OK         = 2'd0;
  localparam gat_status_t ST_TABLE_FULL = 2'd1;
  localparam gat_status_t ST_LIST_FULL  = 2'd2;

endpackage

[hdl/graph_adjacency_table_top.sv]
// Undirected graph adjacency table with a label scan and neighbor scan sequencer.
//
//  channel  signals                                          direction
//  cfg      cfg_valid/cfg_ready, vertex_limit                 write
//  in       in_valid/in_ready, op, first_label, second_label,
//           vertex_index                                      request in
//  out      out_valid/out_ready, edge_found, edge_total,
//           vertex_label, label_known, degree, status         result out
//
// One request at a time; in_ready is high only while the sequencer is idle.
// Add edge and has edge run a label scan, and has edge on a known first label also a neighbor
// list scan, both reading one entry per cycle; count edges and degree query need no scan.
// A finished result waits in the output register; a stalled out channel holds the sequencer
// until the result register frees up. Synchronous reset empties the table (no clearing pass).
module graph_adjacency_table_top
  import gat_pkg::*;
#(
  parameter int MAX_VERTICES = 8,
  parameter int MAX_DEGREE   = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] vertex_limit,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] op,
  input  logic [7:0] first_label,
  input  logic [7:0] second_label,
  input  logic [2:0] vertex_index,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       edge_found,
  output logic [6:0] edge_total,
  output logic [7:0] vertex_label,
  output logic       label_known,
  output logic [4:0] degree,
  output logic [1:0] status
);

  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int POS_W = $clog2(MAX_DEGREE);
  localparam int LU_W  = $clog2(MAX_VERTICES + 1);
  localparam int LL_W  = $clog2(MAX_DEGREE + 1);
  localparam int LLX_W = LL_W + 1;
  localparam int ET_W  = $clog2(MAX_VERTICES * MAX_DEGREE + 1);
  localparam int CNT_W = (LU_W > LL_W) ? LU_W : LL_W;
  localparam int LIM_W = ((LU_W > 4) ? LU_W : 4) + 1;
  localparam int QC_W  = (LU_W > 3) ? LU_W : 3;

  gat_state_t state, state_next;

  // Storage.
  logic [7:0]      label_mem [MAX_VERTICES];
  logic [LL_W-1:0] len_mem   [MAX_VERTICES];
  logic [7:0]      nb_mem    [MAX_VERTICES][MAX_DEGREE];

  logic [7:0]      label_rd;
  logic [LL_W-1:0] len_rd;
  logic [7:0]      nb_rd;

  logic [IDX_W-1:0] label_ra, len_ra, nb_ri;
  logic [POS_W-1:0] nb_rp;
  logic             label_we, len_we, nb_we;
  logic [IDX_W-1:0] label_wa, len_wa, nb_wi;
  logic [POS_W-1:0] nb_wp;
  logic [7:0]       label_wd, nb_wd;
  logic [LL_W-1:0]  len_wd;

  // Control and working registers.
  logic [3:0]       vlim;
  logic [LU_W-1:0]  labels_used;
  logic [ET_W-1:0]  entry_total;
  gat_op_t          op_r;
  logic [7:0]       u_r, v_r;
  logic [2:0]       qi_r;
  logic [CNT_W-1:0] cnt;
  logic             cmp_vld;
  logic [IDX_W-1:0] cmp_idx;
  logic             u_hit, v_hit, v_new;
  logic [IDX_W-1:0] iu, iv, nu, nv;
  logic [1:0]       need;
  logic [LL_W-1:0]  len_u, len_v;
  logic             found;
  gat_status_t      stat;
  logic [7:0]       q_label;
  logic             q_known;
  logic [LL_W-1:0]  q_deg;

  // Combinational helpers.
  logic [LIM_W-1:0] lim_ext, eff_limit, need_sum;
  logic [1:0]       need_c;
  logic             over;
  logic             scan_more, nb_more;
  logic             self_loop;
  logic [LL_W-1:0]  lv;
  logic             len_over;
  logic [IDX_W-1:0] base_idx, nu_c, nv_c;
  logic [POS_W-1:0] pos_v;
  logic [IDX_W-1:0] qi_idx;
  logic             q_valid;
  logic [ET_W-1:0]  half;
  logic             out_load;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign out_load  = (state == S_RESP) && (!out_valid || out_ready);

  always_comb begin
    lim_ext = LIM_W'(vlim);
    if (vlim == 4'd0) begin
      eff_limit = LIM_W'(1);
    end else if (lim_ext > LIM_W'(MAX_VERTICES)) begin
      eff_limit = LIM_W'(MAX_VERTICES);
    end else begin
      eff_limit = lim_ext;
    end
    need_c    = {1'b0, !u_hit} + {1'b0, (op_r == OP_ADD) && (v_r != u_r) && !v_hit};
    need_sum  = LIM_W'(labels_used) + LIM_W'(need_c);
    // Has edge on a known first label is never refused for a full label table.
    over      = (need_sum > eff_limit) && ((op_r == OP_ADD) || !u_hit);
    scan_more = cnt < CNT_W'(labels_used);
    nb_more   = (cnt < CNT_W'(len_u)) && !found;
    self_loop = (v_r == u_r);
    lv        = v_new ? '0 : len_rd;
    if (self_loop) begin
      len_over = LLX_W'(len_u) + LLX_W'(2) > LLX_W'(MAX_DEGREE);
    end else begin
      len_over = (LLX_W'(len_u) + LLX_W'(1) > LLX_W'(MAX_DEGREE)) ||
                 (LLX_W'(lv) + LLX_W'(1) > LLX_W'(MAX_DEGREE));
    end
    // New labels take the next free indices, first label first.
    base_idx = IDX_W'(labels_used);
    nu_c     = u_hit ? iu : base_idx;
    if (self_loop) begin
      nv_c = nu_c;
    end else if (v_hit) begin
      nv_c = iv;
    end else begin
      nv_c = u_hit ? base_idx : IDX_W'(base_idx + IDX_W'(1));
    end
    pos_v   = self_loop ? POS_W'(len_u + LL_W'(1)) : POS_W'(len_v);
    qi_idx  = IDX_W'(qi_r);
    q_valid = QC_W'(qi_r) < QC_W'(labels_used);
    half    = entry_total >> 1;
  end

  // Memory port control.
  always_comb begin
    label_ra = cnt[IDX_W-1:0];
    len_ra   = nu;
    nb_ri    = nu;
    nb_rp    = cnt[POS_W-1:0];
    label_we = 1'b0;
    label_wa = nu;
    label_wd = u_r;
    len_we   = 1'b0;
    len_wa   = nu;
    len_wd   = '0;
    nb_we    = 1'b0;
    nb_wi    = nu;
    nb_wp    = POS_W'(len_u);
    nb_wd    = v_r;
    unique case (state)
      S_LEN_V: len_ra = nv;
      S_Q: begin
        label_ra = qi_idx;
        len_ra   = qi_idx;
      end
      S_WR_U: begin
        label_we = !u_hit;
        len_we   = 1'b1;
        len_wd   = len_u + LL_W'(1);
        nb_we    = 1'b1;
      end
      S_WR_V: begin
        label_we = v_new;
        label_wa = nv;
        label_wd = v_r;
        len_we   = 1'b1;
        len_wa   = nv;
        len_wd   = LL_W'(pos_v) + LL_W'(1);
        nb_we    = 1'b1;
        nb_wi    = nv;
        nb_wp    = pos_v;
        nb_wd    = u_r;
      end
      S_REG: begin
        label_we = 1'b1;
        len_we   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (label_we) begin
      label_mem[label_wa] <= label_wd;
    end
    if (len_we) begin
      len_mem[len_wa] <= len_wd;
    end
    if (nb_we) begin
      nb_mem[nb_wi][nb_wp] <= nb_wd;
    end
    label_rd <= label_mem[label_ra];
    len_rd   <= len_mem[len_ra];
    nb_rd    <= nb_mem[nb_ri][nb_rp];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (op) inside
            OP_ADD, OP_HAS: state_next = S_SCAN;
            OP_DEGREE:      state_next = S_Q;
            default:        state_next = S_RESP;
          endcase
        end
      end
      S_SCAN: begin
        if (!scan_more && !cmp_vld) begin
          if (over) begin
            state_next = S_RESP;
          end else if (op_r == OP_ADD || u_hit) begin
            state_next = S_LEN_U;
          end else begin
            state_next = S_REG;
          end
        end
      end
      S_LEN_U: state_next = S_LEN_V;
      S_LEN_V: state_next = (op_r == OP_ADD) ? S_CHECK : S_NB;
      S_CHECK: state_next = len_over ? S_RESP : S_WR_U;
      S_WR_U:  state_next = S_WR_V;
      S_WR_V:  state_next = S_RESP;
      S_REG:   state_next = S_RESP;
      S_NB: begin
        if (!nb_more && !cmp_vld) begin
          state_next = S_RESP;
        end
      end
      S_Q:     state_next = S_QD;
      S_QD:    state_next = S_RESP;
      S_RESP: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      vlim        <= 4'd6;
      labels_used <= '0;
      entry_total <= '0;
      cmp_vld     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        vlim <= vertex_limit;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          cmp_vld <= 1'b0;
          if (in_valid) begin
            op_r    <= op;
            u_r     <= first_label;
            v_r     <= second_label;
            qi_r    <= vertex_index;
            cnt     <= '0;
            u_hit   <= 1'b0;
            v_hit   <= 1'b0;
            found   <= 1'b0;
            stat    <= ST_OK;
            q_label <= '0;
            q_known <= 1'b0;
            q_deg   <= '0;
          end
        end
        S_SCAN: begin
          // Reads are issued one label per cycle; each compare runs in the cycle after its read.
          cmp_vld <= scan_more;
          cmp_idx <= cnt[IDX_W-1:0];
          if (scan_more) begin
            cnt <= cnt + CNT_W'(1);
          end
          if (cmp_vld) begin
            if (label_rd == u_r) begin
              u_hit <= 1'b1;
              iu    <= cmp_idx;
            end
            if (label_rd == v_r) begin
              v_hit <= 1'b1;
              iv    <= cmp_idx;
            end
          end
          if (!scan_more && !cmp_vld) begin
            nu    <= nu_c;
            nv    <= nv_c;
            need  <= need_c;
            v_new <= !self_loop && !v_hit;
            if (over) begin
              stat <= ST_TABLE_FULL;
            end
          end
        end
        S_LEN_V: begin
          len_u <= u_hit ? len_rd : '0;
          cnt   <= '0;
        end
        S_CHECK: begin
          len_v <= lv;
          if (len_over) begin
            stat <= ST_LIST_FULL;
          end
        end
        S_WR_U: entry_total <= entry_total + ET_W'(1);
        S_WR_V: begin
          entry_total <= entry_total + ET_W'(1);
          labels_used <= labels_used + LU_W'(need);
        end
        S_REG: labels_used <= labels_used + LU_W'(1);
        S_NB: begin
          cmp_vld <= nb_more;
          if (nb_more) begin
            cnt <= cnt + CNT_W'(1);
          end
          if (cmp_vld && nb_rd == v_r) begin
            found <= 1'b1;
          end
        end
        S_QD: begin
          if (q_valid) begin
            q_label <= label_rd;
            q_known <= 1'b1;
            q_deg   <= len_rd;
          end
        end
        default: ;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      edge_found   <= found;
      edge_total   <= 7'(half);
      vertex_label <= q_label;
      label_known  <= q_known;
      degree       <= 5'(q_deg);
      status       <= stat;
    end
  end

endmodule
